[hw/rtl/text_terminal_cursor_engine_assert.svh]
// Assertion macros for the checker file of the cursor engine.
// Each expects signals named clock and reset in the scope of its use.
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg
// Types, geometry and character codes of the text terminal cursor engine.
// ----------------------------------------------------------------------------
package tte_pkg;

   localparam int COLUMNS = 40;
   localparam int ROWS    = 24;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   localparam int COL_W  = 6;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 7;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CODE_DEL   = 7'h7F;
   localparam logic [CHAR_W-1:0] CODE_CR    = 7'h0D;
   localparam logic [CHAR_W-1:0] CODE_BS    = 7'h08;
   localparam logic [CHAR_W-1:0] CODE_ESC   = 7'h1B;
   localparam logic [CHAR_W-1:0] CODE_SPACE = 7'h20;

   typedef struct packed {
      logic       op;
      logic [7:0] char_in;
      logic [4:0] read_row;
      logic [5:0] read_col;
   } req_type;

   typedef struct packed {
      logic [5:0] cursor_col;
      logic [4:0] cursor_row;
      logic [6:0] read_char;
      logic       scrolled;
      logic       cleared;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_FLUSH,
      ST_IDLE,
      ST_READ,
      ST_DONE
   } state_type;

   // Linear cell address of a row and column on the screen.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
   endfunction

endpackage

[hw/rtl/tte_ram.sv]
// ----------------------------------------------------------------------------
// tte_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tte_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/text_terminal_cursor_engine.sv]
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// Cursor engine of a glass-tty text terminal with a character screen store.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Beat
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_ready | op, char_in, read_row, read_col
//   rsp     | out       | rsp_valid / rsp_ready | cursor, read_char, flags
//
// A character, CR, backspace or ignored code goes from the accepted beat
// through the done state to the result register; a cell read passes the
// read state first. Scrolling and clearing sweep the whole store through
// the single RAM write port, one cell per cycle, then pass the flush state.
// After reset the store is filled with spaces by the same sweep, during which
// req_ready stays low.
// The block holds one item at a time; a result that is not taken holds the
// block in its done state, with req_ready low, until rsp is free.
//
module text_terminal_cursor_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tte_pkg::rsp_type rsp_data
);

   import tte_pkg::*;

   // Sequencer state and the sweep counter, which addresses the cells in a sweep.
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              sweep_clear_ff, sweep_clear_in;   // blank every cell
   logic              sweep_item_ff, sweep_item_in;     // sweep belongs to an item

   // Cursor.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // One pending write per cycle. During a scroll the data comes straight
   // from the RAM read issued the cycle before, one row further down.
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              wr_use_ram_ff, wr_use_ram_in;
   logic [CHAR_W-1:0] wr_data_ff, wr_data_in;

   // Result under construction and the output register.
   logic              rd_ok_ff, rd_ok_in;
   logic [CHAR_W-1:0] res_read_ff, res_read_in;
   logic              res_scr_ff, res_scr_in;
   logic              res_clr_ff, res_clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // RAM side.
   logic [ADDR_W-1:0] rd_addr;
   logic [CHAR_W-1:0] rd_data;
   logic [CHAR_W-1:0] ram_wr_data;

   // Decode of the beat on offer.
   logic [CHAR_W-1:0] ch;
   logic              is_cr, is_bs, is_esc, is_print;
   logic              at_eol, at_bottom, in_range;
   logic              accept, rsp_free, sweep_last, sweep_blank;

   assign ch        = req_data.char_in[CHAR_W-1:0];
   assign is_cr     = (ch == CODE_CR);
   assign is_bs     = (ch == CODE_BS);
   assign is_esc    = (ch == CODE_ESC);
   assign is_print  = (ch >= CODE_SPACE) && (ch != CODE_DEL);
   assign at_eol    = (col_ff == COL_W'(COLUMNS - 1));
   assign at_bottom = (row_ff == ROW_W'(ROWS - 1));
   assign in_range  = (32'(req_data.read_row) < 32'(ROWS))
                   && (32'(req_data.read_col) < 32'(COLUMNS));

   assign accept      = (state_ff == ST_IDLE) && req_valid;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign sweep_last  = (cnt_ff == ADDR_W'(CELLS - 1));
   // The bottom row of a scroll has no source row below it, so it is blanked.
   assign sweep_blank = sweep_clear_ff || (cnt_ff >= ADDR_W'(CELLS - COLUMNS));

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_FLUSH;
            end
         end
         // The flush state lets the last copy write land before anything else reads.
         ST_FLUSH: begin
            state_in = sweep_item_ff ? ST_DONE : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_data.op == OP_READ) begin
                  state_in = ST_READ;
               end else if (is_esc) begin
                  state_in = ST_SWEEP;
               end else if (is_cr && at_bottom) begin
                  state_in = ST_SWEEP;
               end else if (is_print && at_eol && at_bottom) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath control
   // ------------------------------------------------------------------------
   always_comb begin
      cnt_in         = cnt_ff;
      sweep_clear_in = sweep_clear_ff;
      sweep_item_in  = sweep_item_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      wr_pend_in     = 1'b0;
      wr_addr_in     = wr_addr_ff;
      wr_use_ram_in  = 1'b0;
      wr_data_in     = wr_data_ff;
      rd_ok_in       = rd_ok_ff;
      res_read_in    = res_read_ff;
      res_scr_in     = res_scr_ff;
      res_clr_in     = res_clr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rd_addr        = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            // Copy cell cnt + COLUMNS down to cnt; the write follows next cycle.
            cnt_in        = ADDR_W'(cnt_ff + ADDR_W'(1));
            wr_pend_in    = 1'b1;
            wr_addr_in    = cnt_ff;
            wr_use_ram_in = !sweep_blank;
            wr_data_in    = CODE_SPACE;
            rd_addr       = sweep_blank ? '0 : ADDR_W'(cnt_ff + ADDR_W'(COLUMNS));
         end
         ST_FLUSH: begin
         end
         ST_IDLE: begin
            if (accept) begin
               res_read_in    = '0;
               res_scr_in     = 1'b0;
               res_clr_in     = 1'b0;
               cnt_in         = '0;
               sweep_item_in  = 1'b1;
               sweep_clear_in = 1'b0;
               priority if (req_data.op == OP_READ) begin
                  rd_ok_in = in_range;
                  rd_addr  = in_range ? cell_addr(req_data.read_row, req_data.read_col)
                                      : '0;
               end else if (is_cr) begin
                  col_in = '0;
                  if (at_bottom) begin
                     res_scr_in = 1'b1;
                  end else begin
                     row_in = ROW_W'(row_ff + ROW_W'(1));
                  end
               end else if (is_bs) begin
                  // Nothing happens at the left margin.
                  if (col_ff != '0) begin
                     col_in     = COL_W'(col_ff - COL_W'(1));
                     wr_pend_in = 1'b1;
                     wr_addr_in = cell_addr(row_ff, COL_W'(col_ff - COL_W'(1)));
                     wr_data_in = CODE_SPACE;
                  end
               end else if (is_esc) begin
                  col_in         = '0;
                  row_in         = '0;
                  res_clr_in     = 1'b1;
                  sweep_clear_in = 1'b1;
               end else if (is_print) begin
                  wr_pend_in = 1'b1;
                  wr_addr_in = cell_addr(row_ff, col_ff);
                  wr_data_in = ch;
                  if (at_eol) begin
                     col_in = '0;
                     if (at_bottom) begin
                        res_scr_in = 1'b1;
                     end else begin
                        row_in = ROW_W'(row_ff + ROW_W'(1));
                     end
                  end else begin
                     col_in = COL_W'(col_ff + COL_W'(1));
                  end
               end else begin
               end
            end
         end
         ST_READ: begin
            res_read_in = rd_ok_ff ? rd_data : '0;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.cursor_col = col_ff;
               rsp_data_in.cursor_row = row_ff;
               rsp_data_in.read_char  = res_read_ff;
               rsp_data_in.scrolled   = res_scr_ff;
               rsp_data_in.cleared    = res_clr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         // Reset starts a clearing sweep of the whole store.
         state_ff       <= ST_SWEEP;
         cnt_ff         <= '0;
         sweep_clear_ff <= 1'b1;
         sweep_item_ff  <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
         wr_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         sweep_clear_ff <= sweep_clear_in;
         sweep_item_ff  <= sweep_item_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         wr_pend_ff     <= wr_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff    <= wr_addr_in;
      wr_use_ram_ff <= wr_use_ram_in;
      wr_data_ff    <= wr_data_in;
      rd_ok_ff      <= rd_ok_in;
      res_read_ff   <= res_read_in;
      res_scr_ff    <= res_scr_in;
      res_clr_ff    <= res_clr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ------------------------------------------------------------------------
   // Screen store
   // ------------------------------------------------------------------------
   assign ram_wr_data = wr_use_ram_ff ? rd_data : wr_data_ff;

   tte_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/tte_checker.sv]
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks on the cursor engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_terminal_cursor_engine_assert.svh"

module tte_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tte_pkg::rsp_type rsp_data
);

   import tte_pkg::*;

   logic rsp_stall;
   logic req_accept;
   logic cursor_on_screen;
   logic clear_at_home;

   assign rsp_stall        = rsp_valid && !rsp_ready;
   assign req_accept       = req_valid && req_ready;
   assign cursor_on_screen = (32'(rsp_data.cursor_col) < 32'(COLUMNS))
                          && (32'(rsp_data.cursor_row) < 32'(ROWS));
   assign clear_at_home    = (rsp_data.cursor_col == '0) && (rsp_data.cursor_row == '0)
                          && !rsp_data.scrolled && (rsp_data.read_char == '0);

   // A stalled result beat stays put.
   `TTE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat not held")

   // The engine takes one item at a time.
   `TTE_ASSERT_NEXT(a_one_item, req_accept, !req_ready, "second item accepted back to back")

   // The reported cursor always lies on the screen.
   `TTE_ASSERT_NOW(a_cursor_range, rsp_valid, cursor_on_screen, "cursor off screen")

   // A clear homes the cursor and neither scrolls nor reads.
   `TTE_ASSERT_NOW(a_clear_home, rsp_valid && rsp_data.cleared, clear_at_home, "clear beat inconsistent")

endmodule

bind text_terminal_cursor_engine tte_checker u_tte_checker (.*);
